### hw/rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

  // Width of one queue word.
  localparam int WORD_W = 32;

  // Encodings of the kind field on the input channel.
  localparam logic [2:0] KIND_PUSH_HEAD = 3'd0;
  localparam logic [2:0] KIND_PUSH_TAIL = 3'd1;
  localparam logic [2:0] KIND_POP_HEAD  = 3'd2;
  localparam logic [2:0] KIND_POP_TAIL  = 3'd3;
  localparam logic [2:0] KIND_REMOVE    = 3'd4;
  localparam logic [2:0] KIND_CLEAR     = 3'd5;

  // Status codes on the result channel.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Word returned by a pop on an empty queue.
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // Decoded operation handed from the front end to the execution unit.
  typedef enum logic [2:0] {
    OP_PUSH_HEAD,
    OP_PUSH_TAIL,
    OP_POP_HEAD,
    OP_POP_TAIL,
    OP_REMOVE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] operand;
  } cmd_t;

  // States of the execution unit.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP_WAIT,
    BK_REMOVE
  } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/double_ended_queue_unit.sv
// Channel   | Handshake                | Payload
// ----------+--------------------------+---------------------------------------------
// input     | start, busy              | in_kind, in_operand_value
// result    | out_valid (one cycle)    | out_popped_value, out_status,
//           |                          | out_removed_count, out_occupancy
//
// An accepted beat is written straight into a two-entry command queue.
// The execution unit finishes push, clear, unused kinds and a pop from an empty
// queue in its idle state; a pop from a non-empty queue also passes through a
// wait state (the slot memory read is registered), and remove-value streams every
// held slot through the one read port.
// The result strobe is registered; it rises in the cycle after execution finishes.
// Reset is synchronous and clears pointers, counts and strobes; slots are not
// cleared. busy rises only when the command queue is full; results cannot stall.
`default_nettype none

module double_ended_queue_unit #(
  parameter  int DEPTH = 16,
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [2:0]                        in_kind,
  input  wire logic signed [deq_pkg::WORD_W-1:0] in_operand_value,
  output logic                                   out_valid,
  output logic signed [deq_pkg::WORD_W-1:0]      out_popped_value,
  output logic [1:0]                             out_status,
  output logic [CntW-1:0]                        out_removed_count,
  output logic [CntW-1:0]                        out_occupancy
);
  import deq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // Front end: decode and queue commands.
  deq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_operand_value (in_operand_value),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take)
  );

  // Back end: execute against the slot store.
  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_take          (cmd_take),
    .out_valid         (out_valid),
    .out_popped_value  (out_popped_value),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_occupancy     (out_occupancy)
  );

endmodule

`default_nettype wire

### hw/rtl/deq_front.sv
`default_nettype none

module deq_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [2:0]                        in_kind,
  input  wire logic signed [deq_pkg::WORD_W-1:0] in_operand_value,
  output logic                                   cmd_valid,
  output deq_pkg::cmd_t                          cmd,
  input  wire logic                              cmd_take
);
  import deq_pkg::*;

  cmd_t       entries_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  cmd_t       decoded;

  // Classify the incoming beat into an operation code.
  always_comb begin
    decoded.operand = in_operand_value;
    unique case (in_kind)
      KIND_PUSH_HEAD: decoded.op = OP_PUSH_HEAD;
      KIND_PUSH_TAIL: decoded.op = OP_PUSH_TAIL;
      KIND_POP_HEAD:  decoded.op = OP_POP_HEAD;
      KIND_POP_TAIL:  decoded.op = OP_POP_TAIL;
      KIND_REMOVE:    decoded.op = OP_REMOVE;
      KIND_CLEAR:     decoded.op = OP_CLEAR;
      default:        decoded.op = OP_NOP;
    endcase
  end

  assign busy      = (fill_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = entries_r[rd_ptr_r];

  // Two-entry command queue toward the execution unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_take) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !cmd_take) begin
        fill_r <= fill_r + 2'd1;
      end else if (!push && cmd_take) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/deq_back.sv
`default_nettype none

module deq_back #(
  parameter  int DEPTH = 16,
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cmd_valid,
  input  wire deq_pkg::cmd_t                     cmd,
  output logic                                   cmd_take,
  output logic                                   out_valid,
  output logic signed [deq_pkg::WORD_W-1:0]      out_popped_value,
  output logic [1:0]                             out_status,
  output logic [CntW-1:0]                        out_removed_count,
  output logic [CntW-1:0]                        out_occupancy
);
  import deq_pkg::*;

  localparam int IdxW = $clog2(DEPTH);
  localparam logic [CntW:0]   DepthW   = (CntW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC   = CntW'(DEPTH);
  localparam logic [CntW-1:0] DepthDec = CntW'(DEPTH - 1);

  // Circular slot store with one write and one registered read port.
  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] mem_q;
  logic                     wr_en;
  logic [IdxW-1:0]          wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  logic                     rd_en;
  logic [IdxW-1:0]          rd_addr;

  back_state_t              state_r, state_nxt;
  logic [IdxW-1:0]          head_r, head_nxt;
  logic [CntW-1:0]          count_r, count_nxt;
  logic [CntW-1:0]          rd_idx_r, rd_idx_nxt;
  logic [CntW-1:0]          kept_r, kept_nxt;
  logic                     pend_r, pend_nxt;
  logic signed [WORD_W-1:0] target_r, target_nxt;

  logic                     res_valid;
  logic signed [WORD_W-1:0] res_popped;
  logic [1:0]               res_status;
  logic [CntW-1:0]          res_removed;
  logic [CntW-1:0]          res_occ;

  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_popped_r;
  logic [1:0]               out_status_r;
  logic [CntW-1:0]          out_removed_r;
  logic [CntW-1:0]          out_occ_r;

  logic                     scan_done;

  // Slot index a + b modulo DEPTH, for a below DEPTH and b at most DEPTH.
  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] a,
                                               input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {{(CntW + 1 - IdxW){1'b0}}, a} + {1'b0, b};
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[IdxW-1:0];
  endfunction

  assign scan_done = (rd_idx_r == count_r) && !pend_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_POP_HEAD, OP_POP_TAIL: begin
              if (count_r != '0) begin
                state_nxt = BK_POP_WAIT;
              end
            end
            OP_REMOVE: state_nxt = BK_REMOVE;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_POP_WAIT: state_nxt = BK_IDLE;
      BK_REMOVE: begin
        if (scan_done) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath control and result for each state.
  always_comb begin
    cmd_take    = 1'b0;
    head_nxt    = head_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    kept_nxt    = kept_r;
    pend_nxt    = 1'b0;
    target_nxt  = target_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    res_valid   = 1'b0;
    res_popped  = '0;
    res_status  = ST_OK;
    res_removed = '0;
    res_occ     = count_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          case (cmd.op)
            OP_PUSH_HEAD: begin
              res_valid = 1'b1;
              if (count_r == DepthC) begin
                res_status = ST_FULL;
              end else begin
                head_nxt  = wrap_add(head_r, DepthDec);
                wr_en     = 1'b1;
                wr_addr   = head_nxt;
                wr_data   = cmd.operand;
                count_nxt = count_r + 1'b1;
                res_occ   = count_nxt;
              end
            end
            OP_PUSH_TAIL: begin
              res_valid = 1'b1;
              if (count_r == DepthC) begin
                res_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = wrap_add(head_r, count_r);
                wr_data   = cmd.operand;
                count_nxt = count_r + 1'b1;
                res_occ   = count_nxt;
              end
            end
            OP_POP_HEAD: begin
              if (count_r == '0) begin
                res_valid  = 1'b1;
                res_popped = EMPTY_WORD;
                res_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                head_nxt  = wrap_add(head_r, CntW'(1));
                count_nxt = count_r - 1'b1;
              end
            end
            OP_POP_TAIL: begin
              if (count_r == '0) begin
                res_valid  = 1'b1;
                res_popped = EMPTY_WORD;
                res_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = wrap_add(head_r, count_r - 1'b1);
                count_nxt = count_r - 1'b1;
              end
            end
            OP_REMOVE: begin
              target_nxt = cmd.operand;
              rd_idx_nxt = '0;
              kept_nxt   = '0;
            end
            OP_CLEAR: begin
              res_valid = 1'b1;
              head_nxt  = '0;
              count_nxt = '0;
              res_occ   = '0;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      BK_POP_WAIT: begin
        res_valid  = 1'b1;
        res_popped = mem_q;
      end
      BK_REMOVE: begin
        // Read entry rd_idx while the previous read is compared and compacted.
        if (rd_idx_r != count_r) begin
          rd_en      = 1'b1;
          rd_addr    = wrap_add(head_r, rd_idx_r);
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        if (pend_r && (mem_q != target_r)) begin
          wr_en    = 1'b1;
          wr_addr  = wrap_add(head_r, kept_r);
          wr_data  = mem_q;
          kept_nxt = kept_r + 1'b1;
        end
        if (scan_done) begin
          res_valid   = 1'b1;
          res_removed = count_r - kept_r;
          count_nxt   = kept_r;
          res_occ     = kept_r;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Slot store.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= res_valid;
    end
  end

  // Scan counters and result payload.
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    kept_r   <= kept_nxt;
    target_r <= target_nxt;
    if (res_valid) begin
      out_popped_r  <= res_popped;
      out_status_r  <= res_status;
      out_removed_r <= res_removed;
      out_occ_r     <= res_occ;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_popped_value  = out_popped_r;
  assign out_status        = out_status_r;
  assign out_removed_count = out_removed_r;
  assign out_occupancy     = out_occ_r;

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 313;
  localparam int MAX_GAP = 60;
  localparam int NUM_DIR = 25;

  // Kind codes that the block treats as no-ops.
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  typedef struct {
    logic signed [WORD_W-1:0] popped;
    logic [1:0]               status;
    logic [CNT_W-1:0]         removed;
    logic [CNT_W-1:0]         occupancy;
  } deq_result_t;

  typedef struct {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] operand;
    int                       reps;
    bit                       typed;
    deq_result_t              want;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic [2:0]                 in_kind = '0;
  logic signed [WORD_W-1:0]   in_operand_value = '0;
  logic                       busy;
  logic                       out_valid;
  logic signed [WORD_W-1:0]   out_popped_value;
  logic [1:0]                 out_status;
  logic [CNT_W-1:0]           out_removed_count;
  logic [CNT_W-1:0]           out_occupancy;

  // Shadow copy of the queue contents.
  logic signed [WORD_W-1:0]   shadow_slot [DEPTH];
  int                         shadow_head;
  int                         shadow_count;

  deq_result_t                pending_results [$];
  dir_row_t                   dir_rows [NUM_DIR];
  int                         errors = 0;
  int                         n_ops = 0;
  int                         n_results = 0;
  int                         n_full = 0;
  int                         n_empty = 0;
  int                         n_remove_hits = 0;
  int                         idle_cycles = 0;

  double_ended_queue_unit #(.DEPTH(DEPTH)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_operand_value  (in_operand_value),
    .out_valid         (out_valid),
    .out_popped_value  (out_popped_value),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_occupancy     (out_occupancy)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow queue and return the result it yields.
  function automatic deq_result_t model_deq_op(logic [2:0] kind,
                                               logic signed [WORD_W-1:0] operand);
    deq_result_t res;
    int kept;
    logic signed [WORD_W-1:0] w;
    res = '{popped: '0, status: ST_OK, removed: '0, occupancy: '0};
    case (kind)
      KIND_PUSH_HEAD, KIND_PUSH_TAIL: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (kind == KIND_PUSH_HEAD) begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_slot[shadow_head] = operand;
          shadow_count++;
        end else begin
          shadow_slot[(shadow_head + shadow_count) % DEPTH] = operand;
          shadow_count++;
        end
      end
      KIND_POP_HEAD, KIND_POP_TAIL: begin
        if (shadow_count == 0) begin
          res.popped = EMPTY_WORD;
          res.status = ST_EMPTY;
        end else if (kind == KIND_POP_HEAD) begin
          res.popped = shadow_slot[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end else begin
          res.popped = shadow_slot[(shadow_head + shadow_count - 1) % DEPTH];
          shadow_count--;
        end
      end
      KIND_REMOVE: begin
        // Compact the survivors toward the head, keeping their order.
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          w = shadow_slot[(shadow_head + i) % DEPTH];
          if (w != operand) begin
            shadow_slot[(shadow_head + kept) % DEPTH] = w;
            kept++;
          end
        end
        res.removed = CNT_W'(shadow_count - kept);
        shadow_count = kept;
      end
      KIND_CLEAR: begin
        shadow_count = 0;
        shadow_head = 0;
      end
      default: begin
      end
    endcase
    res.occupancy = CNT_W'(shadow_count);
    return res;
  endfunction

  task automatic report_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: mismatch in %s: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Drive one beat and hold it until the block takes it.
  task automatic send_op(logic [2:0] kind, logic signed [WORD_W-1:0] operand,
                         bit typed, deq_result_t typed_res);
    deq_result_t res;
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_operand_value <= operand;
    do @(posedge clk); while (busy);
    res = model_deq_op(kind, operand);
    if (typed) res = typed_res;
    pending_results.push_back(res);
    if (res.status == ST_FULL) n_full++;
    if (res.status == ST_EMPTY) n_empty++;
    if (res.removed != 0) n_remove_hits++;
  endtask

  // Lower start and wait for every outstanding result.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    deq_result_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected (popped %0d, status %0d)",
                 $time, out_popped_value, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        report_field("popped_value", want.popped, out_popped_value);
        report_field("status", want.status, out_status);
        report_field("removed_count", want.removed, out_removed_count);
        report_field("occupancy", want.occupancy, out_occupancy);
      end
    end
  end

  // Watchdog on cycles where neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int idle_pct [4];
    logic [2:0] kind;
    logic signed [WORD_W-1:0] operand;
    logic signed [WORD_W-1:0] pool [4];
    int r;
    int gap;
    int done;
    bit fill_mode;
    deq_result_t none;

    none = '{popped: '0, status: ST_OK, removed: '0, occupancy: '0};
    pool = '{-32'sd1, 32'sd0, 32'sd7, 32'sh8000_0000};
    // The receiver cannot hold results off, so the phases vary only the sender's idling.
    idle_pct = '{0, 73, 0, 24};
    shadow_head = 0;
    shadow_count = 0;

    // Directed beats: empty pops, unused kinds, extremes, full queue, removals.
    dir_rows = '{
      '{KIND_POP_HEAD,  32'sd0,            1, 1'b1, '{-32'sd1, ST_EMPTY, 0, 0}},
      '{KIND_POP_TAIL,  32'sd0,            1, 1'b1, '{-32'sd1, ST_EMPTY, 0, 0}},
      '{KIND_REMOVE,    32'sd5,            1, 1'b1, '{32'sd0, ST_OK, 0, 0}},
      '{KIND_UNUSED_6,  32'sd0,            1, 1'b1, '{32'sd0, ST_OK, 0, 0}},
      '{KIND_UNUSED_7,  -32'sd1,           1, 1'b1, '{32'sd0, ST_OK, 0, 0}},
      '{KIND_PUSH_TAIL, 32'sh7fff_ffff,    1, 1'b1, '{32'sd0, ST_OK, 0, 1}},
      '{KIND_PUSH_HEAD, 32'sh8000_0000,    1, 1'b1, '{32'sd0, ST_OK, 0, 2}},
      '{KIND_POP_TAIL,  32'sd0,            1, 1'b0, none},
      '{KIND_POP_HEAD,  32'sd0,            1, 1'b0, none},
      '{KIND_PUSH_HEAD, 32'sd0,            1, 1'b1, '{32'sd0, ST_OK, 0, 1}},
      '{KIND_REMOVE,    32'sd0,            1, 1'b1, '{32'sd0, ST_OK, 1, 0}},
      '{KIND_PUSH_HEAD, 32'shaaaa_aaaa,    8, 1'b0, none},
      '{KIND_PUSH_TAIL, 32'sh5555_5555,    8, 1'b0, none},
      '{KIND_PUSH_TAIL, 32'sd1,            1, 1'b1, '{32'sd0, ST_FULL, 0, 16}},
      '{KIND_PUSH_HEAD, 32'sd2,            1, 1'b1, '{32'sd0, ST_FULL, 0, 16}},
      '{KIND_REMOVE,    32'sh5555_5555,    1, 1'b1, '{32'sd0, ST_OK, 8, 8}},
      '{KIND_POP_TAIL,  32'sd0,            1, 1'b0, none},
      '{KIND_POP_HEAD,  32'sd0,            1, 1'b0, none},
      '{KIND_REMOVE,    32'sd12345,        1, 1'b0, none},
      '{KIND_CLEAR,     32'sd0,            1, 1'b1, '{32'sd0, ST_OK, 0, 0}},
      '{KIND_PUSH_TAIL, -32'sd1,          16, 1'b0, none},
      '{KIND_REMOVE,    -32'sd1,           1, 1'b1, '{32'sd0, ST_OK, 16, 0}},
      '{KIND_PUSH_TAIL, 32'sd3,            5, 1'b0, none},
      '{KIND_UNUSED_6,  32'sd3,            1, 1'b0, none},
      '{KIND_CLEAR,     32'sd0,            1, 1'b1, '{32'sd0, ST_OK, 0, 0}}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) begin
        send_op(dir_rows[i].kind, dir_rows[i].operand, dir_rows[i].typed,
                dir_rows[i].want);
        n_ops++;
      end
    end
    drain();

    // Random beats in phases of different sender idling; drain between phases.
    fill_mode = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        // Alternate between filling and emptying so both ends get exercised.
        if ($urandom_range(0, 29) == 0) fill_mode = ~fill_mode;
        r = $urandom_range(0, 99);
        if (r < 2) kind = $urandom_range(0, 1) ? KIND_UNUSED_7 : KIND_UNUSED_6;
        else if (r < 5) kind = KIND_CLEAR;
        else if (r < 17) kind = KIND_REMOVE;
        else if (r < (fill_mode ? 75 : 42))
          kind = $urandom_range(0, 1) ? KIND_PUSH_TAIL : KIND_PUSH_HEAD;
        else
          kind = $urandom_range(0, 1) ? KIND_POP_TAIL : KIND_POP_HEAD;

        // Values from a small pool repeat, so removals find matches.
        case ($urandom_range(0, 3))
          0, 1: operand = $urandom;
          2: operand = pool[$urandom_range(0, 3)];
          default: begin
            if (kind == KIND_REMOVE && shadow_count > 0)
              operand = shadow_slot[(shadow_head + $urandom_range(0, shadow_count - 1))
                                    % DEPTH];
            else
              operand = pool[$urandom_range(0, 3)];
          end
        endcase

        send_op(kind, operand, 1'b0, none);
        n_ops++;
        if (kind != KIND_UNUSED_6 && kind != KIND_UNUSED_7) done++;

        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct[ph]) gap++;
        if (gap > 0) begin
          @(negedge clk);
          start <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      drain();
    end

    // Let any stray result beat show up before judging.
    repeat (40) @(posedge clk);

    $display("Ran %0d operations and checked %0d results over four idling phases.",
             n_ops, n_results);
    $display("Saw %0d pushes to a full queue, %0d pops from empty, %0d removals with hits.",
             n_full, n_empty, n_remove_hits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results still expected", errors,
               pending_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
